### rtl/core/ptd_pkg.sv
// Shared types and constants for the point-to-torus distance pipeline.
package ptd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAJOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MINOR = 3'd7;

    localparam int ROOT_W = 43;
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int H_W = 37;
    localparam int ESUM_W = 78;
    localparam int NSUM_W = 80;
    localparam int SIDE_W = ESUM_W + H_W;

    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [17:0] axis_x;
        logic signed [17:0] axis_y;
        logic signed [17:0] axis_z;
        logic [30:0] major_radius;
        logic [30:0] minor_radius;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic [RAD_W-1:0] radicand;
        logic [SIDE_W-1:0] side;
    } sq_in_t;

    typedef struct packed {
        logic valid;
        logic [ROOT_W-1:0] root;
        logic [SIDE_W-1:0] side;
    } sq_out_t;

endpackage

### rtl/core/ptd_intf.sv
// Valid/ready channel interfaces for query points and distance results.
interface ptd_point_if;
    logic valid;
    logic ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface ptd_dist_if;
    logic valid;
    logic ready;
    logic [30:0] surface_distance;
    modport source (output valid, output surface_distance, input ready);
    modport sink (input valid, input surface_distance, output ready);
endinterface

### rtl/core/ptd_front.sv
// Front pipeline: offset, axial height, in-plane offset and squared lengths.
module ptd_front
    import ptd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  cfg_t                cfg,
    input  logic                in_valid,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    output sq_in_t              res
);

    logic [8:0] v_reg;

    // stage 1
    logic signed [32:0] d1x_reg, d1y_reg, d1z_reg;
    // stage 2
    logic signed [32:0] d2x_reg, d2y_reg, d2z_reg;
    logic signed [50:0] px_reg, py_reg, pz_reg;
    logic signed [50:0] px_next, py_next, pz_next;
    // stage 3
    logic signed [32:0] d3x_reg, d3y_reg, d3z_reg;
    logic signed [H_W-1:0] h3_reg, h3_next;
    logic signed [52:0] hsum;
    // stage 4
    logic signed [32:0] d4x_reg, d4y_reg, d4z_reg;
    logic signed [H_W-1:0] h4_reg;
    logic signed [54:0] qx_reg, qy_reg, qz_reg, qx_next, qy_next, qz_next;
    // stage 5
    logic signed [38:0] ex_next, ey_next, ez_next;
    logic signed [39:0] nx_reg, ny_reg, nz_reg, nx_next, ny_next, nz_next;
    logic signed [38:0] ex_reg, ey_reg, ez_reg;
    logic signed [H_W-1:0] h5_reg;
    // stage 6
    logic [39:0] mag_reg [6];
    logic [39:0] mag_next [6];
    logic signed [H_W-1:0] h6_reg;
    // stage 7
    logic [39:0] pp_hh_reg [6];
    logic [39:0] pp_hl_reg [6];
    logic [39:0] pp_ll_reg [6];
    logic signed [H_W-1:0] h7_reg;
    // stage 8
    logic [79:0] sq_reg [6];
    logic [79:0] sq_next [6];
    logic signed [H_W-1:0] h8_reg;
    // stage 9
    logic [NSUM_W-1:0] nsum_reg;
    logic [ESUM_W-1:0] esum_reg;
    logic signed [H_W-1:0] h9_reg;

    always_comb
    begin
        px_next = d1x_reg * cfg.axis_x;
        py_next = d1y_reg * cfg.axis_y;
        pz_next = d1z_reg * cfg.axis_z;
        hsum = 53'(px_reg) + 53'(py_reg) + 53'(pz_reg);
        h3_next = H_W'(hsum >>> 16);
        qx_next = cfg.axis_x * h3_reg;
        qy_next = cfg.axis_y * h3_reg;
        qz_next = cfg.axis_z * h3_reg;
        ex_next = 39'(qx_reg >>> 16);
        ey_next = 39'(qy_reg >>> 16);
        ez_next = 39'(qz_reg >>> 16);
        nx_next = 40'(d4x_reg) - 40'(ex_next);
        ny_next = 40'(d4y_reg) - 40'(ey_next);
        nz_next = 40'(d4z_reg) - 40'(ez_next);
        mag_next[0] = nx_reg[39] ? 40'(-nx_reg) : 40'(nx_reg);
        mag_next[1] = ny_reg[39] ? 40'(-ny_reg) : 40'(ny_reg);
        mag_next[2] = nz_reg[39] ? 40'(-nz_reg) : 40'(nz_reg);
        mag_next[3] = ex_reg[38] ? 40'(-40'(ex_reg)) : 40'(ex_reg);
        mag_next[4] = ey_reg[38] ? 40'(-40'(ey_reg)) : 40'(ey_reg);
        mag_next[5] = ez_reg[38] ? 40'(-40'(ez_reg)) : 40'(ez_reg);
        for (int i = 0; i < 6; i++)
        begin
            sq_next[i] = (80'(pp_hh_reg[i]) << 40) + (80'(pp_hl_reg[i]) << 21)
                       + 80'(pp_ll_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1x_reg <= 33'(point_x) - 33'(cfg.center_x);
            d1y_reg <= 33'(point_y) - 33'(cfg.center_y);
            d1z_reg <= 33'(point_z) - 33'(cfg.center_z);
            d2x_reg <= d1x_reg;
            d2y_reg <= d1y_reg;
            d2z_reg <= d1z_reg;
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            d3x_reg <= d2x_reg;
            d3y_reg <= d2y_reg;
            d3z_reg <= d2z_reg;
            h3_reg <= h3_next;
            d4x_reg <= d3x_reg;
            d4y_reg <= d3y_reg;
            d4z_reg <= d3z_reg;
            h4_reg <= h3_reg;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            nz_reg <= nz_next;
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            ez_reg <= ez_next;
            h5_reg <= h4_reg;
            mag_reg <= mag_next;
            h6_reg <= h5_reg;
            for (int i = 0; i < 6; i++)
            begin
                pp_hh_reg[i] <= mag_reg[i][39:20] * mag_reg[i][39:20];
                pp_hl_reg[i] <= mag_reg[i][39:20] * mag_reg[i][19:0];
                pp_ll_reg[i] <= mag_reg[i][19:0] * mag_reg[i][19:0];
            end
            h7_reg <= h6_reg;
            sq_reg <= sq_next;
            h8_reg <= h7_reg;
            nsum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            esum_reg <= ESUM_W'(sq_reg[3]) + ESUM_W'(sq_reg[4]) + ESUM_W'(sq_reg[5]);
            h9_reg <= h8_reg;
        end
    end

    assign res.valid = v_reg[8];
    assign res.radicand = RAD_W'(nsum_reg);
    assign res.side = {esum_reg, h9_reg};

endmodule

### rtl/core/ptd_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module ptd_isqrt
    import ptd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  sq_in_t  din,
    output sq_out_t dout
);

    logic [REM_W-1:0]  rem_reg [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic [ROOT_W-1:0] valid_reg;

    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [RAD_W-1:0]  rad_next [ROOT_W];

    always_comb
    begin
        logic [REM_W-1:0]  rin;
        logic [ROOT_W-1:0] qin;
        logic [RAD_W-1:0]  nin;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              ge;
        for (int s = 0; s < ROOT_W; s++)
        begin
            if (s == 0)
            begin
                rin = '0;
                qin = '0;
                nin = din.radicand;
            end
            else
            begin
                rin = rem_reg[s-1];
                qin = root_reg[s-1];
                nin = rad_reg[s-1];
            end
            cur = {rin[ROOT_W-1:0], nin[RAD_W-1 -: 2]};
            trial = {qin, 2'b01};
            ge = (cur >= trial);
            rem_next[s] = ge ? REM_W'(cur - trial) : cur;
            root_next[s] = {qin[ROOT_W-2:0], ge};
            rad_next[s] = {nin[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[ROOT_W-2:0], din.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            root_reg <= root_next;
            rad_reg <= rad_next;
            side_reg[0] <= din.side;
            for (int s = 1; s < ROOT_W; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign dout.valid = valid_reg[ROOT_W-1];
    assign dout.root = root_reg[ROOT_W-1];
    assign dout.side = side_reg[ROOT_W-1];

endmodule

### rtl/core/ptd_back.sv
// Back pipeline: squared distance to the ring, or to the ring from the axis.
module ptd_back
    import ptd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  cfg_t    cfg,
    input  sq_out_t rho,
    output sq_in_t  res
);

    logic [3:0] v_reg;

    logic signed [H_W-1:0] h_in;
    logic [H_W-1:0] hmag;
    logic signed [43:0] diff;
    logic [41:0] dmag;

    logic [41:0] sel_reg;
    logic on_axis1_reg;
    logic [ESUM_W-1:0] esum1_reg;

    logic [41:0] pp_hh_reg, pp_hl_reg, pp_ll_reg;
    logic [61:0] rsq_reg;
    logic on_axis2_reg;
    logic [ESUM_W-1:0] esum2_reg;

    logic [83:0] sq_reg;
    logic [ESUM_W-1:0] add_reg;
    logic [RAD_W-1:0] d2_reg;

    always_comb
    begin
        h_in = $signed(rho.side[H_W-1:0]);
        hmag = h_in[H_W-1] ? H_W'(-h_in) : H_W'(h_in);
        diff = $signed({1'b0, rho.root}) - $signed({13'b0, cfg.major_radius});
        dmag = diff[43] ? 42'(-diff) : 42'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], rho.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            on_axis1_reg <= (rho.root == '0);
            sel_reg <= (rho.root == '0) ? 42'(hmag) : dmag;
            esum1_reg <= rho.side[SIDE_W-1:H_W];
            pp_hh_reg <= sel_reg[41:21] * sel_reg[41:21];
            pp_hl_reg <= sel_reg[41:21] * sel_reg[20:0];
            pp_ll_reg <= sel_reg[20:0] * sel_reg[20:0];
            rsq_reg <= cfg.major_radius * cfg.major_radius;
            on_axis2_reg <= on_axis1_reg;
            esum2_reg <= esum1_reg;
            sq_reg <= (84'(pp_hh_reg) << 42) + (84'(pp_hl_reg) << 22) + 84'(pp_ll_reg);
            add_reg <= on_axis2_reg ? ESUM_W'(rsq_reg) : esum2_reg;
            d2_reg <= RAD_W'(sq_reg) + RAD_W'(add_reg);
        end
    end

    assign res.valid = v_reg[3];
    assign res.radicand = d2_reg;
    assign res.side = SIDE_W'(cfg.minor_radius);

endmodule

### rtl/core/point_torus_distance_top.sv
// Top level: configuration registers, pipeline chain and result register.
// Accepts one point per cycle unless the output stalls and returns one
// distance per point, in order, via 9 front stages, a 43-stage square root
// for the in-plane radius, 4 back stages, a second 43-stage square root for
// the ring distance and one output register. Any output stall holds the
// whole pipeline. Write registers only while it is empty (unchecked).
module point_torus_distance_top
    import ptd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    ptd_point_if.sink              pnt_in,
    ptd_dist_if.source             dist_out,
    input  logic                   wr_en,
    input  logic [CFG_IDX_W-1:0]   wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    cfg_t cfg_reg;
    logic en;
    sq_in_t fr_res, bk_res;
    sq_out_t sq1_out, sq2_out;
    logic out_valid_reg;
    logic [30:0] dist_reg, dist_next;
    logic signed [44:0] fin;

    assign en = !out_valid_reg || dist_out.ready;
    assign pnt_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x <= '0;
            cfg_reg.center_y <= '0;
            cfg_reg.center_z <= '0;
            cfg_reg.axis_x <= '0;
            cfg_reg.axis_y <= 18'sd65536;
            cfg_reg.axis_z <= '0;
            cfg_reg.major_radius <= 31'd65536;
            cfg_reg.minor_radius <= 31'd16384;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CENTER_X: cfg_reg.center_x <= wr_data;
                REG_CENTER_Y: cfg_reg.center_y <= wr_data;
                REG_CENTER_Z: cfg_reg.center_z <= wr_data;
                REG_AXIS_X:   cfg_reg.axis_x <= wr_data[17:0];
                REG_AXIS_Y:   cfg_reg.axis_y <= wr_data[17:0];
                REG_AXIS_Z:   cfg_reg.axis_z <= wr_data[17:0];
                REG_MAJOR:    cfg_reg.major_radius <= wr_data[30:0];
                REG_MINOR:    cfg_reg.minor_radius <= wr_data[30:0];
                default:      ;
            endcase
        end
    end

    ptd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .in_valid (pnt_in.valid),
        .point_x  (pnt_in.point_x),
        .point_y  (pnt_in.point_y),
        .point_z  (pnt_in.point_z),
        .res      (fr_res)
    );

    ptd_isqrt u_sqrt_rho (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (fr_res),
        .dout  (sq1_out)
    );

    ptd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cfg   (cfg_reg),
        .rho   (sq1_out),
        .res   (bk_res)
    );

    ptd_isqrt u_sqrt_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (bk_res),
        .dout  (sq2_out)
    );

    // tube radius travels alongside the root
    always_comb
    begin
        fin = $signed({2'b0, sq2_out.root}) - $signed({14'b0, sq2_out.side[30:0]});
        if (fin < 0)
        begin
            dist_next = '0;
        end
        else if (fin > $signed({14'b0, DIST_MAX}))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = fin[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sq2_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
        end
    end

    assign dist_out.valid = out_valid_reg;
    assign dist_out.surface_distance = dist_reg;

`ifndef ASSERT_OFF
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !pnt_in.ready |-> (dist_out.valid && !dist_out.ready))
        else $error("input stalled without output backpressure");

    a_inside_tube_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && sq2_out.valid && (sq2_out.root <= ROOT_W'(cfg_reg.minor_radius)))
        |=> (dist_out.surface_distance == '0))
        else $error("point inside tube gave nonzero distance");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(sq2_out.root) && $stable(sq1_out.root)))
        else $error("pipeline moved during stall");
`endif

endmodule
